// ----- design/adid_pkg.sv -----
// Shared types, constants and character helpers for the aligned DNA identity distance block.
// Has no dependencies. It is used by every module of the block.
package adid_pkg;

    localparam int MAX_COLUMNS = 16384;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = COL_W + 1;
    localparam int SUM_W       = CNT_W + 1;
    localparam int FRAC_W      = 16;
    localparam int DIST_W      = FRAC_W + 1;
    localparam int DIV_STEPS   = DIST_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 14;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CNT_W-1:0]     CNT_MAX        = CNT_W'(MAX_COLUMNS);
    localparam logic [STEP_W-1:0]    STEPS_LAST     = STEP_W'(DIV_STEPS);
    localparam logic [CFG_W-1:0]     WIN_END_RESET  = 14'd16383;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_START  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_END    = 1'b1;

    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CH_G     = 8'h47;
    localparam logic [BYTE_W-1:0] CH_N     = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
    localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_GAP = 8'h20;

    typedef enum logic [0:0] {
        S_COUNT,
        S_DIVIDE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic count_en;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] ch);
        logic [BYTE_W-1:0] up;
        up = ch;
        if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
            up = ch - CASE_GAP;
        end
        return up;
    endfunction

    function automatic logic is_nucleotide(input logic [BYTE_W-1:0] ch);
        logic [BYTE_W-1:0] up;
        up = fold_case(ch);
        return (up == CH_A) || (up == CH_C) || (up == CH_G) || (up == CH_T) || (up == CH_N);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v >= CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
        return r;
    endfunction

endpackage

// ----- design/aligned_dna_identity_distance.sv -----
// Top level of the aligned DNA identity distance block.
// Depends on adid_pkg, adid_ctrl and adid_dp.
//
// Input channel (i_valid / o_stall): one alignment column per transfer, two ASCII
// bytes and a last-column flag. Columns inside the window from window_start to
// window_end (inclusive, set through the write port) add to the letter and match
// counts; the block numbers the columns itself from zero for each pair.
// Output channel (o_valid / i_stall): one transfer per pair, the distance
// 1 - 2*matches/letters in unsigned Q1.16, and no_letters when no letter was seen.
// Throughput: ordinary columns are taken one per cycle while no division runs. The
// last column of a pair starts a restoring divider that produces one quotient bit per
// cycle, and the result is then loaded into the output register; o_stall stays high
// while the division runs and until the result is loaded.
// While the receiver stalls, the finished result holds in the output register and
// columns of the next pair keep streaming in; only the end of the next division
// waits for the register to free.
// Reset (synchronous, active low) clears the counters and column index, empties
// the output register and sets the window to the full range.
module aligned_dna_identity_distance
    import adid_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_first_base,
    input  logic [BYTE_W-1:0]    i_second_base,
    input  logic                 i_last_column,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DIST_W-1:0]    o_distance,
    output logic                 o_no_letters
);

    t_cmd    cmd;
    t_status status;

    // Sequence the column transfers and the division steps.
    adid_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last_column (i_last_column),
        .o_stall       (o_stall),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // Hold the counts, divide and present the result.
    adid_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_first_base  (i_first_base),
        .i_second_base (i_second_base),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_distance    (o_distance),
        .o_no_letters  (o_no_letters)
    );

endmodule

// ----- design/adid_div.sv -----
// Restoring divider, one quotient bit per step, for the Q1.16 distance.
// Depends on adid_pkg.
module adid_div
    import adid_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_start,
    input  logic              i_step,
    input  logic [SUM_W-1:0]  i_diff,
    input  logic [SUM_W-1:0]  i_total,
    output logic [DIST_W-1:0] o_quotient
);

    logic [DIST_W-1:0] r_rem, n_rem;
    logic [SUM_W-1:0]  r_div;
    logic [DIST_W-1:0] r_quo, n_quo;
    logic              ge;
    logic [DIST_W-1:0] rem_sub;

    // Remainder stays below the divisor after each subtract, so the shift fits.
    always_comb begin
        ge      = r_rem >= {1'b0, r_div};
        rem_sub = ge ? (r_rem - {1'b0, r_div}) : r_rem;
        n_rem   = {rem_sub[DIST_W-2:0], 1'b0};
        n_quo   = {r_quo[DIST_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_diff};
            r_div <= i_total;
            r_quo <= '0;
        end else if (i_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient = r_quo;

endmodule

// ----- design/adid_dp.sv -----
// Datapath: window registers, column index, letter and match counters, divider, result register.
// Depends on adid_pkg and adid_div.
module adid_dp
    import adid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [BYTE_W-1:0]  i_first_base,
    input  logic [BYTE_W-1:0]  i_second_base,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [DIST_W-1:0]  o_distance,
    output logic               o_no_letters
);

    logic [COL_W-1:0]  r_win_start, r_win_end, r_col;
    logic [CNT_W-1:0]  r_lf, r_ls, r_mc, n_lf, n_ls, n_mc;
    logic              r_none, r_out_valid;
    logic [DIST_W-1:0] r_distance;
    logic              in_win, l1, l2, hit;
    logic [SUM_W-1:0]  total, twice, diff;
    logic [DIST_W-1:0] quotient;

    always_comb begin
        in_win = (r_col >= r_win_start) && (r_col <= r_win_end);
        l1     = is_nucleotide(i_first_base);
        l2     = is_nucleotide(i_second_base);
        hit    = l1 && l2 && (fold_case(i_first_base) == fold_case(i_second_base));
        n_lf   = (in_win && l1)  ? sat_inc(r_lf) : r_lf;
        n_ls   = (in_win && l2)  ? sat_inc(r_ls) : r_ls;
        n_mc   = (in_win && hit) ? sat_inc(r_mc) : r_mc;
        total  = SUM_W'(n_lf) + SUM_W'(n_ls);
        twice  = {n_mc, 1'b0};
        diff   = (twice <= total) ? total - twice : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= '0;
            r_win_end   <= WIN_END_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIN_START: r_win_start <= i_cfg_data;
                REG_WIN_END:   r_win_end   <= i_cfg_data;
                default:       r_win_start <= r_win_start;
            endcase
        end
    end

    // Clear the pair state when the last column is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_lf  <= '0;
            r_ls  <= '0;
            r_mc  <= '0;
        end else if (i_cmd.div_start) begin
            r_col <= '0;
            r_lf  <= '0;
            r_ls  <= '0;
            r_mc  <= '0;
        end else if (i_cmd.count_en) begin
            r_col <= r_col + COL_W'(1);
            r_lf  <= n_lf;
            r_ls  <= n_ls;
            r_mc  <= n_mc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_none <= (total == '0);
        end
        if (i_cmd.out_load) begin
            r_distance   <= r_none ? '0 : quotient;
            o_no_letters <= r_none;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    adid_div u_div (
        .i_clk      (i_clk),
        .i_start    (i_cmd.div_start),
        .i_step     (i_cmd.div_step),
        .i_diff     (diff),
        .i_total    (total),
        .o_quotient (quotient)
    );

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_distance        = r_distance;

endmodule

// ----- design/adid_ctrl.sv -----
// Controller: takes columns, runs the divider steps and hands the result to the output register.
// Depends on adid_pkg.
module adid_ctrl
    import adid_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last_column,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COUNT;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_stall = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_COUNT: begin
                o_cmd.count_en = i_valid;
                if (i_valid && i_last_column) begin
                    o_cmd.div_start = 1'b1;
                    n_step          = '0;
                    n_state         = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                o_stall = 1'b1;
                if (r_step != STEPS_LAST) begin
                    o_cmd.div_step = 1'b1;
                    n_step         = r_step + STEP_W'(1);
                end else if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_COUNT;
                end
            end
            default: begin
                n_state = S_COUNT;
            end
        endcase
    end

endmodule

// ----- sim/adid_distance_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the aligned DNA identity distance block: it watches both channels
// and the window write port. It predicts each pair's distance and compares results.
// Depends on adid_pkg for widths, register indexes and character constants.
module adid_distance_checker
    import adid_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [BYTE_W-1:0]    i_first_base,
    input  logic [BYTE_W-1:0]    i_second_base,
    input  logic                 i_last_column,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [DIST_W-1:0]    i_distance,
    input  logic                 i_no_letters,
    output int                   o_fail_count,
    output int                   o_outstanding
);

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              no_letters;
    } t_pair_result;

    t_pair_result     pending_distances[$];
    logic [CFG_W-1:0] win_first;
    logic [CFG_W-1:0] win_last;
    logic [COL_W-1:0] column_no;
    logic [CNT_W-1:0] seen_first;
    logic [CNT_W-1:0] seen_second;
    logic [CNT_W-1:0] seen_match;
    int               fails = 0;

    function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] ch);
        return (ch >= CH_LO_A && ch <= CH_LO_Z) ? ch - CASE_GAP : ch;
    endfunction

    function automatic logic is_base(input logic [BYTE_W-1:0] ch);
        logic [BYTE_W-1:0] u;
        u = to_upper(ch);
        return (u == CH_A) || (u == CH_C) || (u == CH_G) || (u == CH_T) || (u == CH_N);
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    // Add one column to the running pair counts; on the last column queue the
    // predicted distance and start a fresh pair.
    task automatic tally_column(input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2,
                                input logic last);
        logic              hit1;
        logic              hit2;
        logic [SUM_W-1:0]  total;
        logic [SUM_W-1:0]  twice;
        logic [SUM_W-1:0]  diff;
        logic [63:0]       quotient;
        t_pair_result      res;
        if (column_no >= win_first && column_no <= win_last) begin
            hit1 = is_base(b1);
            hit2 = is_base(b2);
            if (hit1) seen_first = bump(seen_first);
            if (hit2) seen_second = bump(seen_second);
            if (hit1 && hit2 && to_upper(b1) == to_upper(b2)) seen_match = bump(seen_match);
        end
        column_no = column_no + 1'b1;
        if (last) begin
            total = SUM_W'(seen_first) + SUM_W'(seen_second);
            twice = SUM_W'(seen_match) << 1;
            res   = '0;
            if (total == '0) begin
                res.no_letters = 1'b1;
            end else begin
                diff         = (twice <= total) ? total - twice : '0;
                quotient     = (64'(diff) << FRAC_W) / 64'(total);
                res.distance = quotient[DIST_W-1:0];
            end
            pending_distances = {pending_distances, res};
            column_no   = '0;
            seen_first  = '0;
            seen_second = '0;
            seen_match  = '0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pair_result want;
        if (!i_rst_n) begin
            win_first   = '0;
            win_last    = WIN_END_RESET;
            column_no   = '0;
            seen_first  = '0;
            seen_second = '0;
            seen_match  = '0;
            pending_distances.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WIN_START: win_first = i_cfg_data;
                    REG_WIN_END:   win_last  = i_cfg_data;
                    default: ;
                endcase
            end
            // Compare before predicting: a column taken at this edge cannot
            // have produced the result leaving at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (pending_distances.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result distance %0d no_letters %0b",
                                 $time, i_distance, i_no_letters);
                end else begin
                    want = pending_distances.pop_front();
                    if (i_distance !== want.distance || i_no_letters !== want.no_letters) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: distance %0d no_letters %0b, expected %0d %0b",
                                     $time, i_distance, i_no_letters,
                                     want.distance, want.no_letters);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                tally_column(i_first_base, i_second_base, i_last_column);
        end
        o_outstanding <= pending_distances.size();
        o_fail_count  <= fails;
    end

endmodule

// ----- sim/tb_aligned_dna_identity_distance.sv -----
`timescale 1ns / 100ps
// Top-level testbench for aligned_dna_identity_distance: stimulus, window settings and verdict.
// Depends on adid_pkg, the block itself and adid_distance_checker for prediction.
module tb_aligned_dna_identity_distance;
    import adid_pkg::*;

    // The limit covers the slowest correct run: about 1500 columns with the
    // longest gaps, each a pair of its own with a division and a stalled result.
    localparam int CYCLE_LIMIT = 600000;
    // The last column is followed by stall cycles while the divider runs and the result
    // is valid at their end; wait past the division before touching the window registers.
    localparam int SETTLE_CYCLES = 24;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_first_base;
    logic [BYTE_W-1:0]    i_second_base;
    logic                 i_last_column;
    logic                 o_valid;
    logic                 i_stall;
    logic [DIST_W-1:0]    o_distance;
    logic                 o_no_letters;

    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;
    // When set, neither side idles: gives stretches of back-to-back transfers.
    logic calm = 1'b0;

    aligned_dna_identity_distance dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_first_base  (i_first_base),
        .i_second_base (i_second_base),
        .i_last_column (i_last_column),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_distance    (o_distance),
        .o_no_letters  (o_no_letters)
    );

    adid_distance_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_first_base  (i_first_base),
        .i_second_base (i_second_base),
        .i_last_column (i_last_column),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_distance    (o_distance),
        .i_no_letters  (o_no_letters),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: abandon the run if something hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** aligned_dna_identity_distance: FAILED **");
            $finish;
        end
    end

    // Result side: stall for a random number of cycles before each transfer.
    initial begin : result_sink
        int hold;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
        end
    end

    // Offer one column after a random gap and hold it until the transfer.
    // Valid stays high straight into the next column when the gap is zero.
    task automatic send_column(input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2,
                               input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_first_base  <= b1;
        i_second_base <= b2;
        i_last_column <= last;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
    endtask

    // Stop sending, wait until every predicted result has left the block, then
    // let the divider settle so the window can be rewritten safely.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] first_col,
                              input logic [CFG_W-1:0] last_col);
        write_register(REG_WIN_START, first_col);
        write_register(REG_WIN_END, last_col);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly nucleotide letters of either case, some gaps and arbitrary bytes.
    function automatic logic [BYTE_W-1:0] pick_base();
        logic [BYTE_W-1:0] ch;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                case ($urandom_range(0, 4))
                    0:       ch = CH_A;
                    1:       ch = CH_C;
                    2:       ch = CH_G;
                    3:       ch = CH_T;
                    default: ch = CH_N;
                endcase
                if ($urandom_range(0, 1) == 1) ch = ch | CASE_GAP;
            end
            6:       ch = 8'h2D;
            default: ch = BYTE_W'($urandom_range(0, 255));
        endcase
        return ch;
    endfunction

    // Second sequence mostly follows the first (maybe in the other case) so
    // that matches are common; the rest is independent.
    task automatic send_random_pair(input int columns);
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        for (int i = 0; i < columns; i++) begin
            b1 = pick_base();
            if ($urandom_range(0, 4) < 3)
                b2 = ($urandom_range(0, 1) == 1) ? b1 ^ CASE_GAP : b1;
            else
                b2 = pick_base();
            send_column(b1, b2, i == columns - 1);
        end
    endtask

    task automatic run_random_phase(input int columns);
        int sent;
        int len;
        sent = 0;
        while (sent < columns) begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 16);
            calm = ($urandom_range(0, 5) == 0);
            send_random_pair(len);
            sent += len;
        end
        calm = 1'b0;
        drain_results();
    endtask

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_WIN_START;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_first_base  <= '0;
        i_second_base <= '0;
        i_last_column <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pairs under the reset window: full match, full mismatch,
        // gaps only, then a mix of case, non-letters and high bytes.
        send_column(CH_A, CH_A, 1'b1);
        send_column(CH_C | CASE_GAP, CH_G, 1'b1);
        send_column(8'h2D, 8'h2D, 1'b1);
        send_column(CH_A | CASE_GAP, CH_A, 1'b0);
        send_column(CH_N | CASE_GAP, CH_N, 1'b0);
        send_column(CH_G | CASE_GAP, CH_T | CASE_GAP, 1'b0);
        send_column(8'h78, 8'h58, 1'b0);
        send_column(CH_A | 8'h80, CH_A | CASE_GAP | 8'h80, 1'b0);
        send_column(8'h60, 8'h7B, 1'b0);
        send_column(8'h2E, CH_A, 1'b0);
        send_column(CH_T, 8'h00, 1'b1);
        send_column(8'hFF, 8'h80, 1'b0);
        send_column(8'h5A, 8'h7A, 1'b1);
        send_column(CH_T | CASE_GAP, CH_T, 1'b0);
        send_column(CH_C, CH_C | CASE_GAP, 1'b1);
        drain_results();

        // Window extremes: first column only, last column only, inverted.
        set_window(14'd0, 14'd0);
        run_random_phase(150);
        set_window(14'd16383, 14'd16383);
        run_random_phase(150);
        set_window(14'd5, 14'd3);
        run_random_phase(150);
        set_window(14'd2, 14'd10);
        run_random_phase(250);
        repeat (2) begin
            set_window(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(0, 60)));
            run_random_phase(250);
        end

        set_window(14'd0, 14'd16383);
        run_random_phase(300);

        if (fail_count == 0 && outstanding == 0) begin
            $display("** aligned_dna_identity_distance: PASSED **");
        end else begin
            $display("** aligned_dna_identity_distance: FAILED **");
        end
        $finish;
    end

endmodule
